// File: rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the swing foot trajectory block
// Operand widths and the control word of the shared multiply-accumulate unit
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int MAC_OP_W  = 20;
  localparam int MAC_ACC_W = 64;
  localparam int TRIG_W    = 17;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SWING_HEIGHT   = 1'b0,
    CFG_INV_SWING_TIME = 1'b1
  } cfg_idx_t;

  // control word of the shared unit
  typedef struct packed {
    logic       en;
    logic       load;
    logic [1:0] shift;  // product weight in 16 bit steps
  } mac_ctl_t;

endpackage

// File: rtl/cst_in_if.sv
// ----------------------------------------------------------------------------
// cst_in_if: request channel of the swing foot trajectory block
// One leg sample per request, valid/ready handshake
// ----------------------------------------------------------------------------
interface cst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         leg_index;
  logic               in_contact;
  logic [15:0]        leg_phase;
  logic signed [15:0] meas_x;
  logic signed [15:0] meas_y;
  logic signed [15:0] meas_z;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] body_speed_x;

  modport source (
    output valid, leg_index, in_contact, leg_phase, meas_x, meas_y, meas_z,
           target_x, target_y, body_speed_x,
    input  ready
  );
  modport sink (
    input  valid, leg_index, in_contact, leg_phase, meas_x, meas_y, meas_z,
           target_x, target_y, body_speed_x,
    output ready
  );
endinterface

// File: rtl/cst_out_if.sv
// ----------------------------------------------------------------------------
// cst_out_if: result channel of the swing foot trajectory block
// Foot position and velocity setpoints, valid/ready handshake
// ----------------------------------------------------------------------------
interface cst_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    output ready
  );
endinterface

// File: rtl/cst_mac.sv
// ----------------------------------------------------------------------------
// cst_mac: shared signed multiply-accumulate unit
// One 20x20 product a cycle while ctl.en is set, weighted by 2^(16*shift), loaded or accumulated
// ----------------------------------------------------------------------------
module cst_mac (
  input  logic                                   clk,
  input  cst_pkg::mac_ctl_t                      ctl,
  input  logic signed [cst_pkg::MAC_OP_W-1:0]    op_a,
  input  logic signed [cst_pkg::MAC_OP_W-1:0]    op_b,
  output logic signed [cst_pkg::MAC_ACC_W-1:0]   acc_r
);

  localparam int PW = 2 * cst_pkg::MAC_OP_W;

  logic signed [PW-1:0]                 prod;
  logic signed [cst_pkg::MAC_ACC_W-1:0] prod_ext;
  logic signed [cst_pkg::MAC_ACC_W-1:0] weighted;
  logic signed [cst_pkg::MAC_ACC_W-1:0] acc_nxt;

  assign prod     = op_a * op_b;
  assign prod_ext = cst_pkg::MAC_ACC_W'(prod);

  always_comb begin
    case (ctl.shift)
      2'd0:    weighted = prod_ext;
      2'd1:    weighted = prod_ext <<< 16;
      2'd2:    weighted = prod_ext <<< 32;
      default: weighted = prod_ext <<< 48;
    endcase
    acc_nxt = (ctl.load ? '0 : acc_r) + weighted;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// File: rtl/cst_wave.sv
// ----------------------------------------------------------------------------
// cst_wave: sine and cosine of a phase from a quarter-wave table
// Table in Q1.15 built at elaboration, outputs registered on load
// ----------------------------------------------------------------------------
module cst_wave #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    load,
  input  logic [15:0]                             phase,
  output logic signed [cst_pkg::TRIG_W-1:0]       sin_r,
  output logic signed [cst_pkg::TRIG_W-1:0]       cos_r
);

  localparam int AW = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int RW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SW = 16 + AW;
  localparam logic [AW:0] D1 = (AW + 1)'(SINE_TABLE_DEPTH);
  localparam logic [AW:0] D2 = (AW + 1)'(2 * SINE_TABLE_DEPTH);
  localparam logic [AW:0] D3 = (AW + 1)'(3 * SINE_TABLE_DEPTH);
  localparam logic [AW:0] D4 = (AW + 1)'(4 * SINE_TABLE_DEPTH);
  localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

  typedef logic [15:0] tab_t [SINE_TABLE_DEPTH + 1];

  function automatic logic [15:0] tab_entry(input int k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] val;
    x    = (64'd1686629713 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) sum = sum - $signed(term);
      else            sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    val = (sum + 64'sd16384) >>> 15;
    if (val > 64'sd32768) val = 64'sd32768;
    return val[15:0];
  endfunction

  function automatic tab_t build_tab();
    tab_t t;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      t[k] = tab_entry(k);
    end
    return t;
  endfunction

  localparam tab_t SIN_TAB = build_tab();

  // quadrant folding onto the table
  function automatic logic signed [cst_pkg::TRIG_W-1:0] wave(input logic [AW:0] ang);
    logic [AW:0]  idx;
    logic         neg;
    logic [15:0]  mag;
    if (ang < D1) begin
      idx = ang;       neg = 1'b0;
    end else if (ang < D2) begin
      idx = D2 - ang;  neg = 1'b0;
    end else if (ang < D3) begin
      idx = ang - D2;  neg = 1'b1;
    end else begin
      idx = D4 - ang;  neg = 1'b1;
    end
    mag = SIN_TAB[idx[RW-1:0]];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  logic [SW-1:0] scaled;
  logic [AW:0]   ang_s;
  logic [AW:0]   ang_c;

  assign scaled = SW'(phase) * SW'(4 * SINE_TABLE_DEPTH);
  assign ang_s  = {1'b0, scaled[16 +: AW]};

  always_comb begin
    ang_c = ang_s + D1;
    if (ang_c >= D4) ang_c = ang_c - D4;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sin_r <= wave(ang_s);
      cos_r <= wave(ang_c);
    end
  end

endmodule

// File: rtl/cycloid_swing_foot_trajectory.sv
// ----------------------------------------------------------------------------
// cycloid_swing_foot_trajectory: cycloid swing foot setpoint generator
// Per-leg start points, stance latching and a sequenced fixed point datapath
// ----------------------------------------------------------------------------
//
//  channel  | port      | direction | content
//  ---------+-----------+-----------+-------------------------------------------
//  request  | in_req    | sink      | leg, contact, phase, measured foot, target,
//           |           |           | body speed
//  result   | out_res   | source    | pos_x/y/z and vel_x/y/z, Q3.12, saturated
//  config   | cfg_*     | write     | index 0 swing_height, 1 inv_swing_time
//
//  a swing request steps through the states A, C, D, B, K1, K2, G, L1, L2, L3,
//  H, E, F, I1, I2, J1 and J2, each a pass through the single shared 20x20
//  multiply-accumulate; DONE then registers the result and the sequencer
//  returns to idle, where the next request is accepted
//  stance and unused-leg requests go from idle straight to DONE
//  one request at a time; a finished result sits in the output register and
//  the next request is accepted while it waits
//  a result stalled by out_res.ready holds the sequencer in its last step
//  synchronous active-low reset clears the leg-loaded flags and both offsets
//  and loads the config registers with defaults; start points need no reset
//
module cycloid_swing_foot_trajectory #(
  parameter int LEG_COUNT        = 4,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  cst_in_if.sink      in_req,
  cst_out_if.source   out_res,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int LW = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;

  // fixed point constants
  localparam logic signed [19:0] K_INV_2PI  = 20'sd166886;
  localparam logic signed [19:0] K_PI       = 20'sd205887;
  localparam logic signed [19:0] K_EXT_GAIN = 20'sd3277;
  localparam logic signed [19:0] K_LAT_F    = 20'sd1638;
  localparam logic signed [19:0] K_LAT_R    = 20'sd1966;
  localparam logic signed [16:0] EXT_START  = 17'sd8192;
  localparam logic signed [16:0] LAT_START  = 17'sd6144;
  localparam logic signed [15:0] EXT_MAX    = 16'sd410;
  localparam logic signed [15:0] LAT_F_MAX  = 16'sd102;
  localparam logic signed [15:0] LAT_R_MAX  = 16'sd123;
  localparam logic signed [17:0] ONE_Q15    = 18'sd32768;

  typedef enum logic [4:0] {
    ST_IDLE, ST_A, ST_C, ST_D, ST_B, ST_K1, ST_K2, ST_G, ST_L1, ST_L2, ST_L3,
    ST_H, ST_E, ST_F, ST_I1, ST_I2, ST_J1, ST_J2, ST_DONE
  } state_t;

  typedef enum logic [1:0] {KIND_NONE, KIND_STANCE, KIND_SWING} kind_t;

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
    logic signed [63:0] half;
    half = 64'sd1 <<< (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -(((-v) + half) >>> n);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767)  return 16'sh7fff;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  state_t state_r;
  kind_t  kind_r;

  // config
  logic [11:0] swing_height_r;
  logic [15:0] inv_swing_time_r;

  // per-leg store
  logic signed [15:0]   spx_r [LEG_COUNT];
  logic signed [15:0]   spy_r [LEG_COUNT];
  logic signed [15:0]   spz_r [LEG_COUNT];
  logic [LEG_COUNT-1:0] loaded_r;
  logic signed [15:0]   fwd_ext_r;
  logic signed [15:0]   lat_off_r;

  // working copy of the request
  logic [15:0]        p_r;
  logic [1:0]         leg_r;
  logic signed [15:0] v_r;
  logic signed [15:0] tx_r, ty_r;
  logic signed [15:0] wx_r, wy_r, wz_r;

  // intermediate results
  logic signed [17:0] u_r;
  logic signed [16:0] zp_r;
  logic [31:0]        w_r;     // (1-cos) * inv_swing_time
  logic signed [29:0] hs_r;    // height * sin
  logic signed [46:0] hst_r;   // height * sin * inv_swing_time
  logic signed [17:0] xp_r, yp_r;
  logic signed [23:0] vz_r;
  logic signed [26:0] vx_r;

  // output register
  logic               out_valid_r;
  logic signed [15:0] pos_x_r, pos_y_r, pos_z_r, vel_x_r, vel_y_r, vel_z_r;

  logic                                 accept;
  logic [3:0]                           leg_ext;
  logic [LW-1:0]                        leg_sel;
  logic                                 leg_ok;
  logic                                 first_req;
  logic                                 relatch;
  logic signed [cst_pkg::TRIG_W-1:0]    sin_w, cos_w;
  logic signed [17:0]                   om;
  logic signed [16:0]                   dx, dy;
  cst_pkg::mac_ctl_t                    mac_ctl;
  logic signed [cst_pkg::MAC_OP_W-1:0]  mac_a, mac_b;
  logic signed [cst_pkg::MAC_ACC_W-1:0] acc;
  logic signed [63:0]                   r16, r19, r23, r39;
  logic                                 front;
  logic                                 lat_neg;
  logic signed [15:0]                   ext_lim, lat_lim, lat_max;

  assign accept    = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);
  assign leg_ext   = {2'b00, in_req.leg_index};
  assign leg_sel   = leg_ext[LW-1:0];
  assign leg_ok    = leg_ext < 4'(LEG_COUNT);
  assign first_req = !loaded_r[leg_sel];
  assign relatch   = first_req || (in_req.in_contact && !in_req.leg_phase[15]);

  cst_wave #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_wave (
    .clk   (clk),
    .load  (accept),
    .phase (in_req.leg_phase),
    .sin_r (sin_w),
    .cos_r (cos_w)
  );

  cst_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc_r (acc)
  );

  assign om  = ONE_Q15 - 18'(cos_w);
  assign dx  = 17'(tx_r) - 17'(wx_r);
  assign dy  = 17'(ty_r) - 17'(wy_r);
  assign r16 = rnd(acc, 16);
  assign r19 = rnd(acc, 19);
  assign r23 = rnd(acc, 23);
  assign r39 = rnd(acc, 39);

  // lateral offset: front legs lean out on even, rear legs on odd
  assign front   = !leg_r[1];
  assign lat_neg = front ? leg_r[0] : !leg_r[0];
  assign lat_max = front ? LAT_F_MAX : LAT_R_MAX;
  assign ext_lim = (r16 > 64'(EXT_MAX)) ? EXT_MAX : r16[15:0];
  assign lat_lim = (r16 > 64'(lat_max)) ? lat_max : r16[15:0];

  // sequencer step to shared unit operands
  always_comb begin
    mac_ctl = '{en: 1'b1, load: 1'b1, shift: 2'd0};
    mac_a   = '0;
    mac_b   = '0;
    unique case (state_r)
      ST_A: begin
        mac_a = 20'(sin_w);   mac_b = K_INV_2PI;
      end
      ST_C: begin
        mac_a = 20'(om);      mac_b = $signed({4'b0, inv_swing_time_r});
      end
      ST_D: begin
        mac_a = $signed({8'b0, swing_height_r}); mac_b = 20'(sin_w);
      end
      ST_B: begin
        mac_a = $signed({8'b0, swing_height_r}); mac_b = 20'(om);
      end
      ST_K1: begin
        mac_a = $signed({4'b0, hs_r[15:0]}); mac_b = $signed({4'b0, inv_swing_time_r});
      end
      ST_K2: begin
        mac_ctl.load  = 1'b0; mac_ctl.shift = 2'd1;
        mac_a = 20'($signed(hs_r[29:16])); mac_b = $signed({4'b0, inv_swing_time_r});
      end
      ST_G: begin
        mac_a = 20'(dx);      mac_b = 20'(u_r);
      end
      ST_L1: begin
        mac_a = $signed({4'b0, hst_r[15:0]}); mac_b = K_PI;
      end
      ST_L2: begin
        mac_ctl.load  = 1'b0; mac_ctl.shift = 2'd1;
        mac_a = $signed({4'b0, hst_r[31:16]}); mac_b = K_PI;
      end
      ST_L3: begin
        mac_ctl.load  = 1'b0; mac_ctl.shift = 2'd2;
        mac_a = 20'($signed(hst_r[46:32])); mac_b = K_PI;
      end
      ST_H: begin
        mac_a = 20'(dy);      mac_b = 20'(u_r);
      end
      ST_E: begin
        mac_a = 20'(17'(v_r) - EXT_START); mac_b = K_EXT_GAIN;
      end
      ST_F: begin
        mac_a = 20'(17'(v_r) - LAT_START); mac_b = front ? K_LAT_F : K_LAT_R;
      end
      ST_I1: begin
        mac_a = $signed({4'b0, w_r[15:0]}); mac_b = 20'(dx);
      end
      ST_I2: begin
        mac_ctl.load  = 1'b0; mac_ctl.shift = 2'd1;
        mac_a = $signed({4'b0, w_r[31:16]}); mac_b = 20'(dx);
      end
      ST_J1: begin
        mac_a = $signed({4'b0, w_r[15:0]}); mac_b = 20'(dy);
      end
      ST_J2: begin
        mac_ctl.load  = 1'b0; mac_ctl.shift = 2'd1;
        mac_a = $signed({4'b0, w_r[31:16]}); mac_b = 20'(dy);
      end
      ST_IDLE, ST_DONE: begin
        mac_ctl.en = 1'b0;
      end
      default: begin
        mac_ctl.en = 1'b0;
      end
    endcase
  end

  // config writes, leg-loaded flags and speed-dependent offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swing_height_r   <= 12'd328;
      inv_swing_time_r <= 16'd1280;
      loaded_r         <= '0;
      fwd_ext_r        <= '0;
      lat_off_r        <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == cst_pkg::CFG_SWING_HEIGHT) swing_height_r <= cfg_wdata[11:0];
        if (cfg_index == cst_pkg::CFG_INV_SWING_TIME) inv_swing_time_r <= cfg_wdata;
      end
      if (accept && leg_ok) begin
        loaded_r[leg_sel] <= 1'b1;
      end
      // speed-dependent offsets, only on swing requests above threshold
      if (state_r == ST_F && v_r > 16'(EXT_START)) begin
        fwd_ext_r <= ext_lim;
      end
      if (state_r == ST_I1 && v_r > 16'(LAT_START)) begin
        lat_off_r <= lat_neg ? -lat_lim : lat_lim;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r   <= in_req.leg_phase;
      leg_r <= in_req.leg_index;
      v_r   <= in_req.body_speed_x;
      tx_r  <= in_req.target_x;
      ty_r  <= in_req.target_y;
      if (leg_ok && relatch) begin
        spx_r[leg_sel] <= in_req.meas_x;
        spy_r[leg_sel] <= in_req.meas_y;
        spz_r[leg_sel] <= in_req.meas_z;
        wx_r <= in_req.meas_x;
        wy_r <= in_req.meas_y;
        wz_r <= in_req.meas_z;
      end else begin
        wx_r <= spx_r[leg_sel];
        wy_r <= spy_r[leg_sel];
        wz_r <= spz_r[leg_sel];
      end
    end
    // pick up the previous step's product
    case (state_r)
      ST_C:  u_r   <= $signed({2'b00, p_r}) - 18'(r19);
      ST_D:  w_r   <= acc[31:0];
      ST_B:  hs_r  <= acc[29:0];
      ST_K1: zp_r  <= 17'(r16);
      ST_G:  hst_r <= acc[46:0];
      ST_L1: xp_r  <= 18'(r16);
      ST_H:  vz_r  <= 24'(r39);
      ST_E:  yp_r  <= 18'(r16);
      ST_J1: vx_r  <= 27'(r23);
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= KIND_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_res.ready && state_r != ST_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (!leg_ok) begin
              kind_r <= KIND_NONE;   state_r <= ST_DONE;
            end else if (in_req.in_contact) begin
              kind_r <= KIND_STANCE; state_r <= ST_DONE;
            end else begin
              kind_r <= KIND_SWING;  state_r <= ST_A;
            end
          end
        end
        ST_A:  state_r <= ST_C;
        ST_C:  state_r <= ST_D;
        ST_D:  state_r <= ST_B;
        ST_B:  state_r <= ST_K1;
        ST_K1: state_r <= ST_K2;
        ST_K2: state_r <= ST_G;
        ST_G:  state_r <= ST_L1;
        ST_L1: state_r <= ST_L2;
        ST_L2: state_r <= ST_L3;
        ST_L3: state_r <= ST_H;
        ST_H:  state_r <= ST_E;
        ST_E:  state_r <= ST_F;
        ST_F:  state_r <= ST_I1;
        ST_I1: state_r <= ST_I2;
        ST_I2: state_r <= ST_J1;
        ST_J1: state_r <= ST_J2;
        ST_J2: state_r <= ST_DONE;
        ST_DONE: begin
          if (!out_valid_r || out_res.ready) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
            case (kind_r)
              KIND_SWING: begin
                pos_x_r <= sat16(32'(xp_r) + 32'(wx_r) + 32'(fwd_ext_r));
                pos_y_r <= sat16(32'(yp_r) + 32'(wy_r) + 32'(lat_off_r));
                pos_z_r <= sat16(32'(zp_r) + 32'(wz_r));
                vel_x_r <= sat16(32'(vx_r));
                vel_y_r <= sat16(32'(27'(r23)));
                vel_z_r <= sat16(32'(vz_r));
              end
              KIND_STANCE: begin
                pos_x_r <= wx_r;
                pos_y_r <= wy_r;
                pos_z_r <= wz_r;
                vel_x_r <= '0;
                vel_y_r <= '0;
                vel_z_r <= '0;
              end
              default: begin
                pos_x_r <= '0;
                pos_y_r <= '0;
                pos_z_r <= '0;
                vel_x_r <= '0;
                vel_y_r <= '0;
                vel_z_r <= '0;
              end
            endcase
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.pos_x = pos_x_r;
  assign out_res.pos_y = pos_y_r;
  assign out_res.pos_z = pos_z_r;
  assign out_res.vel_x = vel_x_r;
  assign out_res.vel_y = vel_y_r;
  assign out_res.vel_z = vel_z_r;

`ifndef SYNTHESIS
  // an accepted request always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  // a result only appears out of the last step
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the last step");

  // a loaded leg stays loaded until reset
  a_loaded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((loaded_r & $past(loaded_r)) == $past(loaded_r)))
    else $error("leg start point flag dropped");

  // shared unit idle while waiting for a request
  a_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mac_ctl.en)
    else $error("shared unit active while idle");
`endif

endmodule
